FILE: sv/rsas_pkg.sv
// Shared types and constants for the rotated sorted array search block.
// Holds field widths, request function codes and the controller/datapath
// command and status structures. No dependencies.
package rsas_pkg;

    // Field widths of the request, response and configuration channels
    localparam int FUNC_W    = 1;
    localparam int INDEX_W   = 10;
    localparam int IN_VAL_W  = 32;
    localparam int POS_W     = 10;
    localparam int COUNT_W   = 11;

    // Request function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 1'b1;

    // Datapath register update selected by the controller
    typedef enum logic [3:0] {
        OP_NONE,
        OP_START,
        OP_MID,
        OP_LOAD_A,
        OP_GO_RIGHT,
        OP_GO_LEFT,
        OP_TURN_LO,
        OP_TURN_MID,
        OP_TURN_MID_M1,
        OP_SRCH_ALL,
        OP_SRCH_LOW,
        OP_SRCH_HIGH,
        OP_RES_HIT_TURN,
        OP_RES_HIT_MID,
        OP_RES_MISS
    } t_dp_op;

    // Store read address source
    typedef enum logic [2:0] {
        RD_NONE,
        RD_MID,
        RD_MID_P1,
        RD_MID_M1,
        RD_LO,
        RD_TURN,
        RD_ZERO
    } t_rd_sel;

    typedef struct packed {
        t_dp_op  op;
        t_rd_sel rd;
        logic    wr;
    } t_cmd;

    typedef struct packed {
        logic hi_lt_lo;
        logic hi_eq_lo;
        logic mid_lt_hi;
        logic mid_gt_lo;
        logic a_gt_rd;
        logic a_lt_rd;
        logic rd_eq_key;
        logic rd_le_key;
    } t_status;

endpackage

FILE: sv/rsas_if.sv
// Valid/ready channel interfaces: request, response and configuration write.
// Depends on rsas_pkg for the field widths.
interface rsas_req_if;
    import rsas_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [INDEX_W-1:0]         index;
    logic signed [IN_VAL_W-1:0] value;

    modport source (output valid, output func, output index, output value, input ready);
    modport sink   (input valid, input func, input index, input value, output ready);
endinterface

interface rsas_rsp_if;
    import rsas_pkg::*;

    logic             valid;
    logic             ready;
    logic             found;
    logic [POS_W-1:0] position;

    modport source (output valid, output found, output position, input ready);
    modport sink   (input valid, input found, input position, output ready);
endinterface

interface rsas_cfg_if;
    import rsas_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/rsas_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rsas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/rsas_ctrl.sv
// Search sequencer: steps the pivot search, the half selection and the
// binary search, at most one store read per cycle. Depends on rsas_pkg.
module rsas_ctrl (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    input  logic [rsas_pkg::FUNC_W-1:0] i_req_func,
    output logic                    o_req_ready,
    output logic                    o_rsp_valid,
    input  logic                    i_rsp_ready,
    input  rsas_pkg::t_status       i_status,
    output rsas_pkg::t_cmd          o_cmd
);
    import rsas_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_T_CHECK,
        S_T_MID,
        S_T_NXT,
        S_T_PRV,
        S_T_LO,
        S_TURN_RD,
        S_TURN_CMP,
        S_ZERO_CMP,
        S_S_CHECK,
        S_S_CMP,
        S_RESULT
    } t_state;

    t_state r_state, n_state;
    logic   r_req_ready;
    logic   r_rsp_valid;
    t_cmd   w_cmd;
    logic   w_req_acc;

    assign w_req_acc = i_req_valid && r_req_ready;

    // Next state and datapath command
    always_comb begin
        n_state = r_state;
        w_cmd   = '{op: OP_NONE, rd: RD_NONE, wr: 1'b0};
        case (r_state)
            S_IDLE: begin
                if (w_req_acc) begin
                    if (i_req_func == FUNC_SEARCH) begin
                        w_cmd.op = OP_START;
                        n_state  = S_T_CHECK;
                    end else begin
                        w_cmd.wr = 1'b1;
                    end
                end
            end
            S_T_CHECK: begin
                if (i_status.hi_lt_lo) begin
                    w_cmd.op = OP_SRCH_ALL;
                    n_state  = S_S_CHECK;
                end else if (i_status.hi_eq_lo) begin
                    w_cmd.op = OP_TURN_LO;
                    n_state  = S_TURN_RD;
                end else begin
                    w_cmd.op = OP_MID;
                    w_cmd.rd = RD_MID;
                    n_state  = S_T_MID;
                end
            end
            S_T_MID: begin
                w_cmd.op = OP_LOAD_A;
                if (i_status.mid_lt_hi) begin
                    w_cmd.rd = RD_MID_P1;
                    n_state  = S_T_NXT;
                end else if (i_status.mid_gt_lo) begin
                    w_cmd.rd = RD_MID_M1;
                    n_state  = S_T_PRV;
                end else begin
                    w_cmd.rd = RD_LO;
                    n_state  = S_T_LO;
                end
            end
            S_T_NXT: begin
                if (i_status.a_gt_rd) begin
                    w_cmd.op = OP_TURN_MID;
                    n_state  = S_TURN_RD;
                end else if (i_status.mid_gt_lo) begin
                    w_cmd.rd = RD_MID_M1;
                    n_state  = S_T_PRV;
                end else begin
                    w_cmd.rd = RD_LO;
                    n_state  = S_T_LO;
                end
            end
            S_T_PRV: begin
                if (i_status.a_lt_rd) begin
                    w_cmd.op = OP_TURN_MID_M1;
                    n_state  = S_TURN_RD;
                end else begin
                    w_cmd.rd = RD_LO;
                    n_state  = S_T_LO;
                end
            end
            S_T_LO: begin
                w_cmd.op = i_status.a_gt_rd ? OP_GO_RIGHT : OP_GO_LEFT;
                n_state  = S_T_CHECK;
            end
            S_TURN_RD: begin
                w_cmd.rd = RD_TURN;
                n_state  = S_TURN_CMP;
            end
            S_TURN_CMP: begin
                if (i_status.rd_eq_key) begin
                    w_cmd.op = OP_RES_HIT_TURN;
                    n_state  = S_RESULT;
                end else begin
                    w_cmd.rd = RD_ZERO;
                    n_state  = S_ZERO_CMP;
                end
            end
            S_ZERO_CMP: begin
                w_cmd.op = i_status.rd_le_key ? OP_SRCH_LOW : OP_SRCH_HIGH;
                n_state  = S_S_CHECK;
            end
            S_S_CHECK: begin
                if (i_status.hi_lt_lo) begin
                    w_cmd.op = OP_RES_MISS;
                    n_state  = S_RESULT;
                end else begin
                    w_cmd.op = OP_MID;
                    w_cmd.rd = RD_MID;
                    n_state  = S_S_CMP;
                end
            end
            S_S_CMP: begin
                if (i_status.rd_eq_key) begin
                    w_cmd.op = OP_RES_HIT_MID;
                    n_state  = S_RESULT;
                end else begin
                    w_cmd.op = i_status.rd_le_key ? OP_GO_RIGHT : OP_GO_LEFT;
                    n_state  = S_S_CHECK;
                end
            end
            S_RESULT: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state and the handshake flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_req_ready <= 1'b1;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_req_ready <= (n_state == S_IDLE);
            r_rsp_valid <= (n_state == S_RESULT);
        end
    end

    assign o_req_ready = r_req_ready;
    assign o_rsp_valid = r_rsp_valid;
    assign o_cmd       = w_cmd;

endmodule

FILE: sv/rsas_dp.sv
// Search datapath: element store, element count, bounds, key and result
// registers, and the compare flags for the sequencer. Depends on rsas_pkg and
// rsas_ram.
module rsas_dp #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [rsas_pkg::COUNT_W-1:0]        i_cfg_data,
    input  logic [rsas_pkg::INDEX_W-1:0]        i_index,
    input  logic signed [rsas_pkg::IN_VAL_W-1:0] i_value,
    input  rsas_pkg::t_cmd                      i_cmd,
    output rsas_pkg::t_status                   o_status,
    output logic                                o_found,
    output logic [rsas_pkg::POS_W-1:0]          o_position
);
    import rsas_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int IW  = AW + 2;
    localparam int XW  = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    localparam int CNW = ((AW + 1 > COUNT_W) ? AW + 1 : COUNT_W) + 1;
    localparam int PW  = (AW > POS_W) ? AW : POS_W;
    localparam int VW  = VALUE_WIDTH;

    logic [COUNT_W-1:0]   r_count;
    logic signed [IW-1:0] r_lo;
    logic signed [IW-1:0] r_hi;
    logic [AW-1:0]        r_mid;
    logic [AW-1:0]        r_turn;
    logic [VW-1:0]        r_key;
    logic [VW-1:0]        r_a;
    logic                 r_found;
    logic [POS_W-1:0]     r_pos;

    logic [CNW-1:0]       w_cnt_ext;
    logic [CNW-1:0]       w_n_ext;
    logic signed [IW-1:0] w_last;
    logic signed [IW-1:0] w_mid_calc;
    logic signed [IW-1:0] w_mid_s;
    logic signed [IW-1:0] w_turn_s;
    logic [XW-1:0]        w_idx_ext;
    logic                 w_idx_ok;
    logic signed [VW-1:0] w_val_wrap;
    logic [VW-1:0]        w_val_bias;
    logic [AW-1:0]        w_raddr;
    logic [VW-1:0]        w_rdata;
    logic [PW-1:0]        w_mid_pw;
    logic [PW-1:0]        w_turn_pw;

    // Used element count, saturated to the store depth
    assign w_cnt_ext = CNW'(r_count);
    assign w_n_ext   = (w_cnt_ext > CNW'(DEPTH)) ? CNW'(DEPTH) : w_cnt_ext;
    assign w_last    = $signed({1'b0, w_n_ext[AW:0]}) - IW'(1);

    // Midpoint of the current bounds
    assign w_mid_calc = r_lo + ((r_hi - r_lo) >>> 1);
    assign w_mid_s    = $signed({2'b00, r_mid});
    assign w_turn_s   = $signed({2'b00, r_turn});

    // Wrap the value to the store width and flip the sign bit so that an
    // unsigned compare orders the values as signed
    assign w_val_wrap = VW'(i_value);
    assign w_val_bias = {~w_val_wrap[VW-1], w_val_wrap[VW-2:0]};

    // Drop writes beyond the store
    assign w_idx_ext = XW'(i_index);
    assign w_idx_ok  = (w_idx_ext < XW'(DEPTH));

    // Select the read address
    always_comb begin
        case (i_cmd.rd)
            RD_MID:    w_raddr = w_mid_calc[AW-1:0];
            RD_MID_P1: w_raddr = r_mid + AW'(1);
            RD_MID_M1: w_raddr = r_mid - AW'(1);
            RD_LO:     w_raddr = r_lo[AW-1:0];
            RD_TURN:   w_raddr = r_turn;
            default:   w_raddr = '0;
        endcase
    end

    rsas_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr && w_idx_ok),
        .i_waddr (w_idx_ext[AW-1:0]),
        .i_wdata (w_val_bias),
        .i_re    (i_cmd.rd != RD_NONE),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Compare flags for the sequencer
    assign o_status.hi_lt_lo  = (r_hi < r_lo);
    assign o_status.hi_eq_lo  = (r_hi == r_lo);
    assign o_status.mid_lt_hi = (w_mid_s < r_hi);
    assign o_status.mid_gt_lo = (w_mid_s > r_lo);
    assign o_status.a_gt_rd   = (r_a > w_rdata);
    assign o_status.a_lt_rd   = (r_a < w_rdata);
    assign o_status.rd_eq_key = (w_rdata == r_key);
    assign o_status.rd_le_key = (w_rdata <= r_key);

    // Reported position, truncated to the port width
    assign w_mid_pw  = PW'(r_mid);
    assign w_turn_pw = PW'(r_turn);

    // Hold the element count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(1);
        end else if (i_cfg_valid) begin
            r_count <= i_cfg_data;
        end
    end

    // Advance bounds, midpoint, compared element, pivot, key and result
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_START: begin
                r_key <= w_val_bias;
                r_lo  <= '0;
                r_hi  <= w_last;
            end
            OP_MID:         r_mid  <= w_mid_calc[AW-1:0];
            OP_LOAD_A:      r_a    <= w_rdata;
            OP_GO_RIGHT:    r_lo   <= w_mid_s + IW'(1);
            OP_GO_LEFT:     r_hi   <= w_mid_s - IW'(1);
            OP_TURN_LO:     r_turn <= r_lo[AW-1:0];
            OP_TURN_MID:    r_turn <= r_mid;
            OP_TURN_MID_M1: r_turn <= r_mid - AW'(1);
            OP_SRCH_ALL: begin
                r_lo <= '0;
                r_hi <= w_last;
            end
            OP_SRCH_LOW: begin
                r_lo <= '0;
                r_hi <= w_turn_s - IW'(1);
            end
            OP_SRCH_HIGH: begin
                r_lo <= w_turn_s + IW'(1);
                r_hi <= w_last;
            end
            OP_RES_HIT_TURN: begin
                r_found <= 1'b1;
                r_pos   <= w_turn_pw[POS_W-1:0];
            end
            OP_RES_HIT_MID: begin
                r_found <= 1'b1;
                r_pos   <= w_mid_pw[POS_W-1:0];
            end
            OP_RES_MISS: begin
                r_found <= 1'b0;
                r_pos   <= '0;
            end
            default: begin
            end
        endcase
    end

    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule

FILE: sv/rotated_sorted_array_search.sv
// Search in a rotated ascending array of distinct signed values held on chip.
// A write request stores one value (an index of DEPTH or above is dropped),
// makes no response and leaves the request channel ready. A search request
// finds the rotation pivot by halving, then binary-searches the half that can
// hold the key, and returns found and position (position 0 when not found).
// Each pivot halving step and each binary search step reads the store, which
// has a single read port with registered data; a search holds off further
// requests, and the request interface is handed back only once the response
// is taken. The element count register is written through the configuration
// channel, which is always ready. There is no clearing pass; unwritten entries
// read as unknown. Depends on rsas_pkg, rsas_if, rsas_ram, rsas_ctrl and
// rsas_dp.
module rotated_sorted_array_search #(
    parameter int DEPTH       = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rsas_req_if.sink    i_req,
    rsas_rsp_if.source  o_rsp,
    rsas_cfg_if.sink    i_cfg
);
    import rsas_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Configuration writes are taken at once
    assign i_cfg.ready = 1'b1;

    rsas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    rsas_dp #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_index     (i_req.index),
        .i_value     (i_req.value),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_found     (o_rsp.found),
        .o_position  (o_rsp.position)
    );

`ifndef SYNTHESIS
    // A pending response blocks new requests
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.ready && o_rsp.valid))
        else $error("request ready while a response is pending");

    // A search holds off further requests
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.func == FUNC_SEARCH) |=> !i_req.ready)
        else $error("request ready right after a search was taken");

    // A write completes in its own cycle
    a_write_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.func == FUNC_WRITE) |=>
        (i_req.ready && !o_rsp.valid))
        else $error("write request stalled the block or made a response");

    // A miss reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.found) |-> (o_rsp.position == '0))
        else $error("miss response with nonzero position");
`endif

endmodule

FILE: test/rotated_sorted_array_search_tb.sv
// Self-checking testbench for rotated_sorted_array_search: fills the store with rotated
// ascending arrays under many element counts and checks every search response.
// Depends on rsas_pkg, rsas_if and the rotated_sorted_array_search RTL.
module rotated_sorted_array_search_tb;
    import rsas_pkg::*;

    localparam int STORE_DEPTH    = 1024;
    localparam int ITEM_TARGET    = 1200;
    localparam int SETTLE_CYCLES  = 80;
    localparam int END_WAIT       = 100;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    localparam logic signed [IN_VAL_W-1:0] MIN_VAL = 32'sh8000_0000;
    localparam logic signed [IN_VAL_W-1:0] MAX_VAL = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_search_result;

    // Mirror of the store and count; predicts each search and checks responses in order
    class t_search_scoreboard;
        logic signed [IN_VAL_W-1:0] mirror [STORE_DEPTH];
        logic [COUNT_W-1:0]         count;
        t_search_result             expected_q [$];
        int mismatches;
        int searches;
        int writes;
        int hits;

        function new();
            count = 1;
        endfunction

        function void set_count(logic [COUNT_W-1:0] c);
            count = c;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Index of the largest element of a rotated run, or -1 once the bounds cross, as for an empty range
        function int find_peak(int lo, int hi);
            int mid;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (mid < hi && mirror[mid] > mirror[mid + 1]) return mid;
                if (mid > lo && mirror[mid] < mirror[mid - 1]) return mid - 1;
                if (mirror[mid] > mirror[lo]) lo = mid + 1;
                else hi = mid - 1;
            end
            return (lo == hi) ? lo : -1;
        endfunction

        function int bisect_range(int lo, int hi, logic signed [IN_VAL_W-1:0] key);
            int mid;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (mirror[mid] == key) return mid;
                if (mirror[mid] > key) hi = mid - 1;
                else lo = mid + 1;
            end
            return -1;
        endfunction

        function t_search_result predict_search(logic signed [IN_VAL_W-1:0] key);
            t_search_result res;
            int last;
            int peak;
            int pos;
            last = ((count > STORE_DEPTH) ? STORE_DEPTH : int'(count)) - 1;
            peak = find_peak(0, last);
            if (peak < 0) pos = bisect_range(0, last, key);
            else if (mirror[peak] == key) pos = peak;
            else if (mirror[0] <= key) pos = bisect_range(0, peak - 1, key);
            else pos = bisect_range(peak + 1, last, key);
            res.found    = (pos >= 0);
            res.position = (pos >= 0) ? pos[POS_W-1:0] : '0;
            return res;
        endfunction

        function void note_request(logic [FUNC_W-1:0] func, logic [INDEX_W-1:0] idx,
                                   logic signed [IN_VAL_W-1:0] value);
            t_search_result res;
            if (func == FUNC_WRITE) begin
                mirror[idx] = value;
                writes++;
            end else begin
                res = predict_search(value);
                if (res.found) hits++;
                expected_q.push_back(res);
                searches++;
            end
        endfunction

        function void check_response(logic found, logic [POS_W-1:0] position);
            t_search_result exp_res;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("response with no search outstanding: found=%0b position=%0d",
                             found, position);
                return;
            end
            exp_res = expected_q.pop_front();
            if (found !== exp_res.found || position !== exp_res.position) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display({"search mismatch: expected found=%0b position=%0d,",
                              " got found=%0b position=%0d"},
                             exp_res.found, exp_res.position, found, position);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    rsas_req_if req_ch ();
    rsas_rsp_if rsp_ch ();
    rsas_cfg_if cfg_ch ();

    rotated_sorted_array_search #(
        .DEPTH       (STORE_DEPTH),
        .VALUE_WIDTH (IN_VAL_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    t_search_scoreboard sb;

    // Current array image, kept in step with writes the stimulus makes
    logic signed [IN_VAL_W-1:0] image [STORE_DEPTH];
    int     image_len;
    longint ramp [STORE_DEPTH];

    bit idling_on;
    bit long_hold_req;
    int random_items;
    int phases;
    int stall_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Sample every handshake at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.func, req_ch.index, req_ch.value);
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.found, rsp_ch.position);
            if (cfg_ch.valid && cfg_ch.ready)
                sb.set_count(cfg_ch.data);
        end
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // End the run when nothing has been accepted for too long
    initial begin
        wait (stall_cycles >= WATCHDOG_LIMIT);
        $display("timeout: no handshake for %0d cycles, %0d responses outstanding",
                 WATCHDOG_LIMIT, sb.pending());
        $display("rotated_sorted_array_search_tb: errors");
        $finish;
    end

    // Response side: random stall bursts, plus one long hold on request
    initial begin
        int n;
        wait (i_rst_n === 1'b1);
        forever begin
            if (long_hold_req) begin
                rsp_ch.ready = 1'b0;
                n = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                rsp_ch.ready = 1'b0;
                n = $urandom_range(1, 12);
            end else begin
                rsp_ch.ready = 1'b1;
                n = $urandom_range(1, 24);
            end
            repeat (n) @(negedge i_clk);
        end
    end

    // Offer one request and hold it until taken; entered and left just after a falling edge
    task automatic send_request(input logic [FUNC_W-1:0] func, input logic [INDEX_W-1:0] idx,
                                input logic signed [IN_VAL_W-1:0] value);
        if (idling_on && $urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        req_ch.func  = func;
        req_ch.index = idx;
        req_ch.value = value;
        req_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Write the count only once the block is idle
    task automatic set_element_count(input int cnt);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_ch.data  = cnt[COUNT_W-1:0];
        cfg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // Build a rotated ascending run of n distinct values: dense, spread, or touching an extreme
    task automatic build_image(input int n);
        longint step_max;
        longint cur;
        longint shift;
        int kind;
        int turn;
        image_len = n;
        if (n == 0) return;
        kind = $urandom_range(0, 3);
        if (kind == 0) begin
            step_max = 3;
            cur = longint'($urandom_range(0, 4000)) - 2000;
        end else begin
            step_max = 64'h0000_0000_FFFF_FFFF / n;
            cur = longint'(MIN_VAL);
            if (!(kind == 1 && $urandom_range(0, 1) == 0))
                cur = cur + longint'($urandom_range(0, step_max));
        end
        for (int i = 0; i < n; i++) begin
            ramp[i] = cur;
            cur = cur + longint'($urandom_range(1, step_max));
        end
        if (kind == 2) begin
            shift = longint'(MAX_VAL) - ramp[n - 1];
            for (int i = 0; i < n; i++) ramp[i] = ramp[i] + shift;
        end
        turn = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, n - 1);
        for (int i = 0; i < n; i++) image[i] = ramp[(i + turn) % n][IN_VAL_W-1:0];
    endtask

    // Mostly keys that are present, some neighbors, extremes and random values
    function automatic logic signed [IN_VAL_W-1:0] pick_key();
        int r;
        int j;
        r = $urandom_range(0, 19);
        j = (image_len > 0) ? $urandom_range(0, image_len - 1) : 0;
        if (image_len > 0 && r < 11) return image[j];
        if (image_len > 0 && r < 15) return r[0] ? image[j] + 32'sd1 : image[j] - 32'sd1;
        if (r < 17) begin
            case ($urandom_range(0, 2))
                0: return MIN_VAL;
                1: return MAX_VAL;
                default: return '0;
            endcase
        end
        return $urandom;
    endfunction

    // One count setting: configure, refill the used range if asked, then searches mixed with stray writes
    task automatic run_phase(input int cnt, input int n_searches, input bit refill,
                             input bit long_hold);
        int n;
        int first;
        int mid_pause;
        int idx;
        logic signed [IN_VAL_W-1:0] value;
        set_element_count(cnt);
        phases++;
        n = (cnt > STORE_DEPTH) ? STORE_DEPTH : cnt;
        if (refill) begin
            build_image(n);
            first = (n > 0) ? $urandom_range(0, n - 1) : 0;
            for (int k = 0; k < n; k++) begin
                idx = (k + first) % n;
                send_request(FUNC_WRITE, idx[INDEX_W-1:0], image[idx]);
                random_items++;
            end
        end
        if (long_hold) long_hold_req = 1'b1;
        mid_pause = ($urandom_range(0, 3) == 0) ? n_searches / 2 : -1;
        for (int k = 0; k < n_searches; k++) begin
            if (k == mid_pause) wait_drained();
            if ($urandom_range(0, 9) == 0) begin
                // stray write: breaks the order when it lands inside the used range
                idx = $urandom_range(0, STORE_DEPTH - 1);
                value = $urandom;
                if (idx < image_len) image[idx] = value;
                send_request(FUNC_WRITE, idx[INDEX_W-1:0], value);
            end else begin
                send_request(FUNC_SEARCH, INDEX_W'($urandom), pick_key());
            end
            random_items++;
        end
    endtask

    initial begin
        int cnt;
        int r;
        sb = new();
        idling_on     = 1'b1;
        long_hold_req = 1'b0;
        random_items  = 0;
        phases        = 0;
        image_len     = 0;
        req_ch.valid  = 1'b0;
        req_ch.func   = FUNC_WRITE;
        req_ch.index  = '0;
        req_ch.value  = '0;
        rsp_ch.ready  = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.data   = '0;
        i_rst_n       = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Single element at the count left by reset, holding each extreme
        send_request(FUNC_WRITE, 10'd0, MIN_VAL);
        send_request(FUNC_SEARCH, 10'd0, MIN_VAL);
        send_request(FUNC_SEARCH, 10'd0, MAX_VAL);
        send_request(FUNC_SEARCH, 10'd0, 32'sd0);
        send_request(FUNC_WRITE, 10'd0, MAX_VAL);
        send_request(FUNC_SEARCH, 10'h3FF, MAX_VAL);
        send_request(FUNC_SEARCH, 10'd0, MIN_VAL);
        // Empty store: every search misses
        set_element_count(0);
        send_request(FUNC_SEARCH, 10'd0, 32'sd5);
        send_request(FUNC_SEARCH, 10'd0, MIN_VAL);
        // Two elements rotated so the largest comes first
        set_element_count(2);
        send_request(FUNC_WRITE, 10'd1, MIN_VAL);
        send_request(FUNC_SEARCH, 10'd0, MAX_VAL);
        send_request(FUNC_SEARCH, 10'd0, MIN_VAL);
        send_request(FUNC_SEARCH, 10'd0, 32'sd0);
        // Three elements, then an unordered and a repeated value
        set_element_count(3);
        send_request(FUNC_WRITE, 10'd0, 32'sd5);
        send_request(FUNC_WRITE, 10'd1, -32'sd7);
        send_request(FUNC_WRITE, 10'd2, 32'sd0);
        send_request(FUNC_SEARCH, 10'd0, 32'sd5);
        send_request(FUNC_SEARCH, 10'd0, -32'sd7);
        send_request(FUNC_SEARCH, 10'd0, 32'sd0);
        send_request(FUNC_SEARCH, 10'd0, 32'sd1);
        send_request(FUNC_WRITE, 10'd2, 32'sd10);
        send_request(FUNC_WRITE, 10'd1, 32'sd5);
        send_request(FUNC_SEARCH, 10'd0, 32'sd5);
        send_request(FUNC_SEARCH, 10'd0, 32'sd10);
        send_request(FUNC_WRITE, 10'h3FF, MIN_VAL);

        // Count extremes, the full store with a long response hold, and saturation
        run_phase(0, 12, 1'b1, 1'b0);
        run_phase(1, 12, 1'b1, 1'b0);
        run_phase(2, 16, 1'b1, 1'b0);
        run_phase(STORE_DEPTH, 60, 1'b1, 1'b1);
        run_phase(2047, 30, 1'b0, 1'b0);
        run_phase(STORE_DEPTH + 1, 20, 1'b0, 1'b0);

        // Mostly small arrays; the tail runs with no idling on either side
        while (random_items < ITEM_TARGET) begin
            if (random_items > ITEM_TARGET * 5 / 6) idling_on = 1'b0;
            r = $urandom_range(0, 9);
            if (r == 0) cnt = $urandom_range(49, 300);
            else if (r == 1) cnt = $urandom_range(0, 3);
            else cnt = $urandom_range(4, 48);
            run_phase(cnt, $urandom_range(15, 40), 1'b1, 1'b0);
        end

        wait_drained();
        repeat (END_WAIT) @(negedge i_clk);
        $display("covered %0d searches (%0d hits) and %0d writes over %0d count settings",
                 sb.searches, sb.hits, sb.writes, phases);
        $display("counts ranged from empty to saturated, %0d mismatches seen", sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("rotated_sorted_array_search_tb: clean");
        end else begin
            $display("rotated_sorted_array_search_tb: errors");
        end
        $finish;
    end

endmodule
